@@ rtl/acpr_pkg.sv @@
// ----------------------------------------------------------------------------
// acpr_pkg
// Shared types and constants for the attribute cell palette renderer.
// ----------------------------------------------------------------------------
package acpr_pkg;

  localparam int PAL_DEPTH = 64;
  localparam int PAL_AW    = 6;
  localparam int ENTRY_W   = 8;
  localparam int RGB_W     = 24;
  localparam int LANES     = 8;

  // command codes
  localparam logic CMD_RENDER = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // request word: one cell row or one palette write
  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_byte;
    logic [7:0] attr_byte;
    logic [5:0] pal_index;
    logic [7:0] pal_value;
  } req_word_t;

  // result word: eight pixel colours, leftmost first
  typedef struct packed {
    logic [23:0] pixel0_rgb;
    logic [23:0] pixel1_rgb;
    logic [23:0] pixel2_rgb;
    logic [23:0] pixel3_rgb;
    logic [23:0] pixel4_rgb;
    logic [23:0] pixel5_rgb;
    logic [23:0] pixel6_rgb;
    logic [23:0] pixel7_rgb;
  } rsp_word_t;

endpackage

@@ rtl/acpr_ram.sv @@
// ----------------------------------------------------------------------------
// acpr_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module acpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ rtl/acpr_expand.sv @@
// ----------------------------------------------------------------------------
// acpr_expand
// Turns one palette entry into a 24-bit colour, with the default grid
// palette standing in for entries never written.
// ----------------------------------------------------------------------------
module acpr_expand (
  input  logic [acpr_pkg::ENTRY_W-1:0] entry,
  input  logic                         entry_valid,
  input  logic [acpr_pkg::PAL_AW-1:0]  addr,
  output logic [acpr_pkg::RGB_W-1:0]   rgb
);
  import acpr_pkg::*;

  // default grid: red odd, green even, blue all; black first, white last
  function automatic logic [ENTRY_W-1:0] grid_entry(input logic [PAL_AW-1:0] idx);
    logic [ENTRY_W-1:0] e;
    begin
      e = {idx[3:2], 1'b0, idx[5:4], 1'b1, idx[1:0]};
      if (idx == '0) begin
        e = '0;
      end else if (idx == '1) begin
        e = '1;
      end
      return e;
    end
  endfunction

  logic [7:0] ent;
  logic [2:0] red3;
  logic [2:0] green3;
  logic [2:0] blue3;
  logic [7:0] red8;
  logic [7:0] green8;
  logic [7:0] blue8;

  assign ent = entry_valid ? entry : grid_entry(addr);

  // bit replication of each channel; blue is zero when its two entry bits are zero
  assign red3   = ent[4:2];
  assign green3 = ent[7:5];
  assign blue3  = {ent[1:0], 1'b1};
  assign red8   = {red3, red3, red3[2:1]};
  assign green8 = {green3, green3, green3[2:1]};
  assign blue8  = (ent[1:0] == 2'b00) ? 8'h00 : {blue3, blue3, blue3[2:1]};

  assign rgb = {blue8, green8, red8};

endmodule

@@ rtl/acpr_lane.sv @@
// ----------------------------------------------------------------------------
// acpr_lane
// One pixel lane: picks ink or paper colour from its bitmap bit.
// ----------------------------------------------------------------------------
module acpr_lane (
  input  logic                       ink_bit,
  input  logic [acpr_pkg::RGB_W-1:0] ink_rgb,
  input  logic [acpr_pkg::RGB_W-1:0] paper_rgb,
  output logic [acpr_pkg::RGB_W-1:0] rgb
);
  import acpr_pkg::*;

  // set bit shows ink, clear bit shows paper
  always_comb begin
    if (ink_bit) begin
      rgb = ink_rgb;
    end else begin
      rgb = paper_rgb;
    end
  end

endmodule

@@ rtl/attribute_cell_palette_renderer.sv @@
// ----------------------------------------------------------------------------
// attribute_cell_palette_renderer
// A render word passes the palette read and lookup stage registers, then the
// result register. Throughput: one word per cycle unless rsp_stall holds,
// set by the two read ports and the result register; writes give no result.
// Reset: synchronous; clears pipeline valids and the palette valid bits, so
// the default grid palette reads back at once, with no clearing pass.
// ----------------------------------------------------------------------------
module attribute_cell_palette_renderer (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  acpr_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output acpr_pkg::rsp_word_t rsp
);
  import acpr_pkg::*;

  logic                 adv_rsp;
  logic                 adv_s1;
  logic                 accept;
  logic                 is_render;
  logic                 is_write;
  logic [PAL_AW-1:0]    ink_addr;
  logic [PAL_AW-1:0]    paper_addr;

  logic [PAL_DEPTH-1:0] written;
  logic                 s1_valid;
  logic [7:0]           s1_pixels;
  logic [PAL_AW-1:0]    s1_ink_addr;
  logic [PAL_AW-1:0]    s1_paper_addr;
  logic                 s1_ink_ok;
  logic                 s1_paper_ok;
  logic [ENTRY_W-1:0]   ink_entry;
  logic [ENTRY_W-1:0]   paper_entry;
  logic [RGB_W-1:0]     ink_rgb;
  logic [RGB_W-1:0]     paper_rgb;
  logic [RGB_W-1:0]     lane_rgb [LANES];
  rsp_word_t            rsp_next;

  // pipeline flow control
  assign adv_rsp   = !rsp_valid || !rsp_stall;
  assign adv_s1    = !s1_valid || adv_rsp;
  assign req_stall = !adv_s1;
  assign accept    = req_valid && adv_s1;
  assign is_render = accept && (req.cmd == CMD_RENDER);
  assign is_write  = accept && (req.cmd == CMD_WRITE);

  // ink from group*16+ink, paper from group*16+8+paper
  assign ink_addr   = {req.attr_byte[7:6], 1'b0, req.attr_byte[2:0]};
  assign paper_addr = {req.attr_byte[7:6], 1'b1, req.attr_byte[5:3]};

  acpr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PAL_DEPTH)
  ) u_palette (
    .clk      (clk),
    .wr_en    (is_write),
    .wr_addr  (req.pal_index),
    .wr_data  (req.pal_value),
    .rd_en    (is_render),
    .rd_addr_a(ink_addr),
    .rd_addr_b(paper_addr),
    .rd_data_a(ink_entry),
    .rd_data_b(paper_entry)
  );

  // per-entry written marks
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (is_write) begin
      written[req.pal_index] <= 1'b1;
    end
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_s1) begin
      s1_valid <= is_render;
    end
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (is_render) begin
      s1_pixels     <= req.pixel_byte;
      s1_ink_addr   <= ink_addr;
      s1_paper_addr <= paper_addr;
      s1_ink_ok     <= written[ink_addr];
      s1_paper_ok   <= written[paper_addr];
    end
  end

  acpr_expand u_expand_ink (
    .entry      (ink_entry),
    .entry_valid(s1_ink_ok),
    .addr       (s1_ink_addr),
    .rgb        (ink_rgb)
  );

  acpr_expand u_expand_paper (
    .entry      (paper_entry),
    .entry_valid(s1_paper_ok),
    .addr       (s1_paper_addr),
    .rgb        (paper_rgb)
  );

  // pixel lanes, lane 0 takes bit 7
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    acpr_lane u_lane (
      .ink_bit  (s1_pixels[LANES-1-k]),
      .ink_rgb  (ink_rgb),
      .paper_rgb(paper_rgb),
      .rgb      (lane_rgb[k])
    );
  end

  // merge lanes into the result word
  always_comb begin
    rsp_next.pixel0_rgb = lane_rgb[0];
    rsp_next.pixel1_rgb = lane_rgb[1];
    rsp_next.pixel2_rgb = lane_rgb[2];
    rsp_next.pixel3_rgb = lane_rgb[3];
    rsp_next.pixel4_rgb = lane_rgb[4];
    rsp_next.pixel5_rgb = lane_rgb[5];
    rsp_next.pixel6_rgb = lane_rgb[6];
    rsp_next.pixel7_rgb = lane_rgb[7];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv_rsp) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_rsp && s1_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/acpr_checker.sv @@
// ----------------------------------------------------------------------------
// acpr_assertions
// Port-level checks of the renderer's flow and result timing.
// ----------------------------------------------------------------------------
module acpr_assertions (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input acpr_pkg::req_word_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input acpr_pkg::rsp_word_t rsp
);
  import acpr_pkg::*;

  logic render_acc;
  logic blank_acc;

  assign render_acc = req_valid && !req_stall && (req.cmd == CMD_RENDER);
  assign blank_acc  = render_acc && (req.pixel_byte == 8'h00);

  // a held result word stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // request side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a stalled result");

  // a new result traces back to an accepted render word
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(render_acc, 2))
    else $error("result word without a render word");

  // an all-paper row arrives on time with eight equal pixels
  a_blank_row: assert property (@(posedge clk) disable iff (rst)
    blank_acc ##1 !(rsp_valid && rsp_stall) |=> rsp_valid
      && rsp.pixel0_rgb == rsp.pixel1_rgb && rsp.pixel1_rgb == rsp.pixel2_rgb
      && rsp.pixel2_rgb == rsp.pixel3_rgb && rsp.pixel3_rgb == rsp.pixel4_rgb
      && rsp.pixel4_rgb == rsp.pixel5_rgb && rsp.pixel5_rgb == rsp.pixel6_rgb
      && rsp.pixel6_rgb == rsp.pixel7_rgb)
    else $error("all-paper row gave unequal or late pixels");

endmodule

bind attribute_cell_palette_renderer acpr_assertions u_acpr_assertions (.*);
